// ===== hdl/lrsp_pkg.sv =====
// ----------------------------------------------------------------------------
// lrsp_pkg
// Shared types and constants for the log record stream parser: phase codes,
// register indexes, parser state and result word layout.
// ----------------------------------------------------------------------------
`default_nettype none

package lrsp_pkg;

    // Field widths
    localparam int BYTE_W   = 8;
    localparam int LEN_W    = 16;
    localparam int TXN_W    = 64;
    localparam int ROLE_W   = 3;
    localparam int CNT_W    = 16;
    localparam int CFG_IDX_W = 1;

    // Number of transaction id bytes in a header
    localparam int TXN_BYTES = TXN_W / BYTE_W;

    // Phase codes, also the byte role reported for each byte
    typedef logic [ROLE_W-1:0] t_phase;
    localparam t_phase PH_LEN  = 3'd0;
    localparam t_phase PH_TXN  = 3'd1;
    localparam t_phase PH_OP   = 3'd2;
    localparam t_phase PH_KLEN = 3'd3;
    localparam t_phase PH_KEY  = 3'd4;
    localparam t_phase PH_VLEN = 3'd5;
    localparam t_phase PH_VAL  = 3'd6;

    // Configuration register indexes
    typedef logic [CFG_IDX_W-1:0] t_cfg_idx;
    localparam t_cfg_idx REG_PUT_CODE    = 1'd0;
    localparam t_cfg_idx REG_DELETE_CODE = 1'd1;

    // Reset values of the op code registers
    localparam logic [BYTE_W-1:0] PUT_CODE_RST    = 8'd3;
    localparam logic [BYTE_W-1:0] DELETE_CODE_RST = 8'd4;

    // Parser state carried from byte to byte
    typedef struct packed {
        t_phase             phase;
        logic [CNT_W-1:0]   field_count;
        logic [LEN_W-1:0]   length;
        logic [TXN_W-1:0]   txn;
        logic [BYTE_W-1:0]  op;
        logic [LEN_W-1:0]   key_len;
        logic [LEN_W-1:0]   val_len;
    } t_state;

    // One result word
    typedef struct packed {
        t_phase             byte_role;
        logic [BYTE_W-1:0]  byte_out;
        logic [LEN_W-1:0]   record_length;
        logic [TXN_W-1:0]   txn_id;
        logic [BYTE_W-1:0]  op_code;
        logic [LEN_W-1:0]   key_length;
        logic [LEN_W-1:0]   value_length;
        logic               record_done;
        logic               truncated;
    } t_result;

endpackage

`default_nettype wire

// ===== hdl/lrsp_if.sv =====
// ----------------------------------------------------------------------------
// lrsp_if
// Valid/ready channels of the parser: raw stream bytes in, tagged words out.
// ----------------------------------------------------------------------------
`default_nettype none

interface lrsp_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       stream_end;

    modport source (output valid, output data_byte, output stream_end, input ready);
    modport sink   (input valid, input data_byte, input stream_end, output ready);
endinterface

interface lrsp_out_if;
    logic        valid;
    logic        ready;
    logic [2:0]  byte_role;
    logic [7:0]  byte_out;
    logic [15:0] record_length;
    logic [63:0] txn_id;
    logic [7:0]  op_code;
    logic [15:0] key_length;
    logic [15:0] value_length;
    logic        record_done;
    logic        truncated;

    modport source (
        output valid, output byte_role, output byte_out, output record_length,
        output txn_id, output op_code, output key_length, output value_length,
        output record_done, output truncated, input ready
    );
    modport sink (
        input valid, input byte_role, input byte_out, input record_length,
        input txn_id, input op_code, input key_length, input value_length,
        input record_done, input truncated, output ready
    );
endinterface

`default_nettype wire

// ===== hdl/lrsp_step.sv =====
// ----------------------------------------------------------------------------
// lrsp_step
// Per-byte parse logic: from the current state and one stream byte, form the
// next state and the tagged result word.
// ----------------------------------------------------------------------------
`default_nettype none

module lrsp_step (
    input  wire lrsp_pkg::t_state   i_state,
    input  wire logic [7:0]         i_data_byte,
    input  wire logic               i_stream_end,
    input  wire logic [7:0]         i_put_code,
    input  wire logic [7:0]         i_delete_code,
    output lrsp_pkg::t_state        o_next,
    output lrsp_pkg::t_result       o_result
);
    import lrsp_pkg::*;

    logic             done;
    logic             is_put;
    logic [LEN_W-1:0] len_hi;
    logic [CNT_W:0]   cnt_inc;

    // Shared helpers
    assign is_put  = (i_state.op == i_put_code);
    assign cnt_inc = {1'b0, i_state.field_count} + {{CNT_W{1'b0}}, 1'b1};

    // Next state
    always_comb begin
        o_next = i_state;
        done   = 1'b0;
        len_hi = {i_data_byte, 8'h00};
        case (i_state.phase)
            PH_LEN: begin
                if (i_state.field_count == '0) begin
                    o_next.length      = {8'h00, i_data_byte};
                    o_next.txn         = '0;
                    o_next.op          = '0;
                    o_next.key_len     = '0;
                    o_next.val_len     = '0;
                    o_next.field_count = CNT_W'(1);
                end else begin
                    o_next.length      = i_state.length | len_hi;
                    o_next.field_count = '0;
                    o_next.phase       = PH_TXN;
                end
            end
            PH_TXN: begin
                // OR the byte into its lane
                for (int k = 0; k < TXN_BYTES; k++) begin
                    if (i_state.field_count[2:0] == 3'(k)) begin
                        o_next.txn[BYTE_W*k +: BYTE_W] =
                            i_state.txn[BYTE_W*k +: BYTE_W] | i_data_byte;
                    end
                end
                if (i_state.field_count >= CNT_W'(TXN_BYTES - 1)) begin
                    o_next.field_count = '0;
                    o_next.phase       = PH_OP;
                end else begin
                    o_next.field_count = cnt_inc[CNT_W-1:0];
                end
            end
            PH_OP: begin
                o_next.op          = i_data_byte;
                o_next.field_count = '0;
                if (i_data_byte == i_put_code || i_data_byte == i_delete_code) begin
                    o_next.phase = PH_KLEN;
                end else begin
                    done         = 1'b1;
                    o_next.phase = PH_LEN;
                end
            end
            PH_KLEN: begin
                if (i_state.field_count == '0) begin
                    o_next.key_len     = {8'h00, i_data_byte};
                    o_next.field_count = CNT_W'(1);
                end else begin
                    o_next.key_len     = i_state.key_len | len_hi;
                    o_next.field_count = '0;
                    if (o_next.key_len != '0) begin
                        o_next.phase = PH_KEY;
                    end else if (is_put) begin
                        o_next.phase = PH_VLEN;
                    end else begin
                        done         = 1'b1;
                        o_next.phase = PH_LEN;
                    end
                end
            end
            PH_KEY: begin
                if (cnt_inc >= {1'b0, i_state.key_len}) begin
                    o_next.field_count = '0;
                    if (is_put) begin
                        o_next.phase = PH_VLEN;
                    end else begin
                        done         = 1'b1;
                        o_next.phase = PH_LEN;
                    end
                end else begin
                    o_next.field_count = cnt_inc[CNT_W-1:0];
                end
            end
            PH_VLEN: begin
                if (i_state.field_count == '0) begin
                    o_next.val_len     = {8'h00, i_data_byte};
                    o_next.field_count = CNT_W'(1);
                end else begin
                    o_next.val_len     = i_state.val_len | len_hi;
                    o_next.field_count = '0;
                    if (o_next.val_len != '0) begin
                        o_next.phase = PH_VAL;
                    end else begin
                        done         = 1'b1;
                        o_next.phase = PH_LEN;
                    end
                end
            end
            default: begin
                // value bytes
                if (cnt_inc >= {1'b0, i_state.val_len}) begin
                    o_next.field_count = '0;
                    done               = 1'b1;
                    o_next.phase       = PH_LEN;
                end else begin
                    o_next.field_count = cnt_inc[CNT_W-1:0];
                end
            end
        endcase

        // End of buffer always restarts framing
        if (i_stream_end) begin
            o_next.phase       = PH_LEN;
            o_next.field_count = '0;
        end
    end

    // Result word reflects the fields after this byte
    always_comb begin
        o_result.byte_role     = i_state.phase;
        o_result.byte_out      = i_data_byte;
        o_result.record_length = o_next.length;
        o_result.txn_id        = o_next.txn;
        o_result.op_code       = o_next.op;
        o_result.key_length    = o_next.key_len;
        o_result.value_length  = o_next.val_len;
        o_result.record_done   = done;
        o_result.truncated     = i_stream_end & ~done;
    end

endmodule

`default_nettype wire

// ===== hdl/lrsp_out_stage.sv =====
// ----------------------------------------------------------------------------
// lrsp_out_stage
// Result register: holds one word for the sink and refills in the same cycle
// the held word is taken.
// ----------------------------------------------------------------------------
`default_nettype none

module lrsp_out_stage (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_load,
    input  wire lrsp_pkg::t_result  i_result,
    output logic                    o_can_load,
    lrsp_out_if.source              o_rec
);
    import lrsp_pkg::*;

    logic    r_valid;
    logic    n_valid;
    t_result r_res;

    // Free when empty or draining this cycle
    assign o_can_load = ~r_valid | o_rec.ready;
    assign n_valid    = i_load | (r_valid & ~o_rec.ready);

    // Valid flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    // Payload
    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_res <= i_result;
        end
    end

    assign o_rec.valid         = r_valid;
    assign o_rec.byte_role     = r_res.byte_role;
    assign o_rec.byte_out      = r_res.byte_out;
    assign o_rec.record_length = r_res.record_length;
    assign o_rec.txn_id        = r_res.txn_id;
    assign o_rec.op_code       = r_res.op_code;
    assign o_rec.key_length    = r_res.key_length;
    assign o_rec.value_length  = r_res.value_length;
    assign o_rec.record_done   = r_res.record_done;
    assign o_rec.truncated     = r_res.truncated;

endmodule

`default_nettype wire

// ===== hdl/log_record_stream_parser_core.sv =====
// Each accepted byte's tagged word is registered in the result register.
// Throughput: one byte per cycle, sustained; the result register refills in
// the cycle its word is taken, so only a stalled sink holds off input.
// Reset (synchronous, active low): framing restarts at a length field, all
// assembled fields clear, op codes return to put 3 and delete 4.
// ----------------------------------------------------------------------------
// log_record_stream_parser_core
// Tags each byte of a back-to-back log record stream with its role and
// reports the assembled header, key length and value length fields.
// ----------------------------------------------------------------------------
`default_nettype none

module log_record_stream_parser_core (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_cfg_wr_en,
    input  wire lrsp_pkg::t_cfg_idx         i_cfg_index,
    input  wire logic [lrsp_pkg::BYTE_W-1:0] i_cfg_wdata,
    lrsp_in_if.sink                         i_byte,
    lrsp_out_if.source                      o_rec
);
    import lrsp_pkg::*;

    logic [BYTE_W-1:0] r_put_code;
    logic [BYTE_W-1:0] r_delete_code;
    t_state            r_state;
    t_state            n_state;
    t_result           step_res;
    logic              can_load;
    logic              accept;

    assign i_byte.ready = can_load;
    assign accept       = i_byte.valid & can_load;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_put_code    <= PUT_CODE_RST;
            r_delete_code <= DELETE_CODE_RST;
        end else if (i_cfg_wr_en) begin
            case (i_cfg_index)
                REG_PUT_CODE:    r_put_code    <= i_cfg_wdata;
                REG_DELETE_CODE: r_delete_code <= i_cfg_wdata;
                default: begin
                end
            endcase
        end
    end

    // Parser state advances once per accepted byte
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= '{phase: PH_LEN, default: '0};
        end else if (accept) begin
            r_state <= n_state;
        end
    end

    lrsp_step u_step (
        .i_state       (r_state),
        .i_data_byte   (i_byte.data_byte),
        .i_stream_end  (i_byte.stream_end),
        .i_put_code    (r_put_code),
        .i_delete_code (r_delete_code),
        .o_next        (n_state),
        .o_result      (step_res)
    );

    lrsp_out_stage u_out (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_load     (accept),
        .i_result   (step_res),
        .o_can_load (can_load),
        .o_rec      (o_rec)
    );

endmodule

`default_nettype wire
